FILE: hdl/rdsg_pkg.sv
// shared constants and types for the rds group decoder
package rdsg_pkg;

  localparam int TEXT_CHARS = 64;
  localparam int TEXT_AW    = $clog2(TEXT_CHARS);
  localparam int NAME_CHARS = 8;
  localparam int NAME_AW    = $clog2(NAME_CHARS);
  localparam int MAX_FREQS  = 25;
  localparam int LEN_W      = $clog2(TEXT_CHARS + 1);

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_NAME   = 2'd2;
  localparam logic [1:0] KIND_FREQ   = 2'd3;

  localparam logic [3:0] GTYPE_BASIC = 4'd0;
  localparam logic [3:0] GTYPE_TEXT  = 4'd2;

  localparam logic [7:0]  AF_COUNT_BASE  = 8'd224;
  localparam logic [7:0]  AF_COUNT_END   = 8'(224 + MAX_FREQS + 1);
  localparam logic [7:0]  AF_ENTRY_LIMIT = 8'd205;
  localparam logic [10:0] FREQ_BASE      = 11'd875;
  localparam logic [7:0]  CHAR_CR        = 8'h0D;
  localparam logic [7:0]  CHAR_SPACE     = 8'h20;
  localparam logic [1:0]  FLAG_INVALID   = 2'b10;

  typedef struct packed {
    logic               clr;
    logic               wr_en;
    logic [TEXT_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
  } txt_ctl_t;

endpackage

FILE: hdl/rds_group_decoder_top.sv
// rds group decoder top level: sequencer, group decode, name and af state, output register
// a text group: 4 store writes, a scan of up to 64 chars, then 64 text items at one per
// cycle unless stalled, or 1 status item on a zero char; a name/af group is decoded, then
// up to 10 items; others 1 item; no new group is accepted until the last item is loaded
// reset: synchronous on rst_n low; empties both stores, marks the text a/b flag invalid and
// zeroes text length, pi code and af count and index; no clearing pass is needed
module rds_group_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [15:0] in_block_a,
  input  logic [15:0] in_block_b,
  input  logic [15:0] in_block_c,
  input  logic [15:0] in_block_d,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [5:0]  out_index,
  output logic [10:0] out_value,
  output logic [6:0]  out_text_length,
  output logic [15:0] out_pi_code,
  output logic [4:0]  out_af_count,
  output logic        out_last
);

  localparam int AW = rdsg_pkg::TEXT_AW;
  localparam int NW = rdsg_pkg::NAME_AW;
  localparam int LW = rdsg_pkg::LEN_W;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_WRITE  = 9'b000000010,
    ST_SCAN   = 9'b000000100,
    ST_TEXT   = 9'b000001000,
    ST_GRP0   = 9'b000010000,
    ST_AF0    = 9'b000100000,
    ST_AF1    = 9'b001000000,
    ST_NAME   = 9'b010000000,
    ST_STATUS = 9'b100000000
  } state_t;

  typedef struct packed {
    logic        req;
    logic [1:0]  kind;
    logic [5:0]  index;
    logic [10:0] value;
    logic        last;
  } emit_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   pub_len_r, pub_len_nxt;
  logic [15:0]     pi_r, pi_nxt;
  logic [1:0]      ab_flag_r, ab_flag_nxt;
  logic [4:0]      freq_total_r, freq_total_nxt;
  logic [4:0]      freq_next_r, freq_next_nxt;
  logic [7:0]      name_r [rdsg_pkg::NAME_CHARS];
  logic [7:0]      name_nxt [rdsg_pkg::NAME_CHARS];

  logic [15:0]     blk_c_r, blk_d_r;
  logic [3:0]      seg_r;
  logic            ver_b_r;
  logic            e1_r, full_r;
  logic [4:0]      af_idx0_r, af_idx1_r;
  logic            grp0_load;

  logic            out_valid_r;
  logic [1:0]      out_kind_r;
  logic [5:0]      out_index_r;
  logic [10:0]     out_value_r;
  logic [6:0]      out_text_length_r;
  logic [15:0]     out_pi_code_r;
  logic [4:0]      out_af_count_r;
  logic            out_last_r;

  rdsg_pkg::txt_ctl_t txt_ctl;
  logic [7:0]      txt_char;
  emit_t           emit;
  logic            in_acc;
  logic            slot_free;
  logic            load;
  logic [LW-1:0]   scan_len;

  // af and name decode for group 0
  logic [7:0]      af0, af1, cnt_code0, cnt_code1;
  logic            is_cnt0, is_cnt1;
  logic [4:0]      total_a, next_a, next_b, next_c;
  logic            e0, e1, name_full;

  rdsg_text_store u_text (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (txt_ctl),
    .rd_addr (cnt_nxt),
    .rd_char (txt_char)
  );

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign load      = emit.req && slot_free;

  always_comb begin
    af0       = blk_c_r[15:8];
    af1       = blk_c_r[7:0];
    cnt_code0 = af0 - rdsg_pkg::AF_COUNT_BASE;
    cnt_code1 = af1 - rdsg_pkg::AF_COUNT_BASE;
    is_cnt0   = (af0 > rdsg_pkg::AF_COUNT_BASE) && (af0 < rdsg_pkg::AF_COUNT_END);
    is_cnt1   = (af1 > rdsg_pkg::AF_COUNT_BASE) && (af1 < rdsg_pkg::AF_COUNT_END);
    if (ver_b_r) begin
      total_a = freq_total_r;
      next_a  = freq_next_r;
    end else if (is_cnt1) begin
      total_a = cnt_code1[4:0];
      next_a  = 5'd0;
    end else if (is_cnt0) begin
      total_a = cnt_code0[4:0];
      next_a  = 5'd0;
    end else begin
      total_a = freq_total_r;
      next_a  = freq_next_r;
    end
    e0 = !ver_b_r && (af0 != 8'd0) && (af0 < rdsg_pkg::AF_ENTRY_LIMIT) && (next_a < total_a);
    next_b = next_a + {4'd0, e0};
    e1 = !ver_b_r && (af1 != 8'd0) && (af1 < rdsg_pkg::AF_ENTRY_LIMIT) && (next_b < total_a);
    next_c = next_b + {4'd0, e1};
    name_full = 1'b1;
    for (int i = 0; i < rdsg_pkg::NAME_CHARS; i++) begin
      if (name_r[i] == 8'd0) begin
        name_full = 1'b0;
      end
    end
  end

  assign scan_len = (txt_char != rdsg_pkg::CHAR_SPACE) ? (LW'(cnt_r) + LW'(1)) : len_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    len_nxt        = len_r;
    pub_len_nxt    = pub_len_r;
    pi_nxt         = pi_r;
    ab_flag_nxt    = ab_flag_r;
    freq_total_nxt = freq_total_r;
    freq_next_nxt  = freq_next_r;
    name_nxt       = name_r;
    grp0_load      = 1'b0;
    txt_ctl        = '0;
    emit           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command) begin
            txt_ctl.clr    = 1'b1;
            pub_len_nxt    = '0;
            pi_nxt         = 16'd0;
            ab_flag_nxt    = rdsg_pkg::FLAG_INVALID;
            freq_total_nxt = 5'd0;
            freq_next_nxt  = 5'd0;
            for (int i = 0; i < rdsg_pkg::NAME_CHARS; i++) begin
              name_nxt[i] = 8'd0;
            end
            state_nxt = ST_STATUS;
          end else begin
            pi_nxt = in_block_a;
            if (in_block_b[15:12] == rdsg_pkg::GTYPE_TEXT && !in_block_b[11]) begin
              // a/b flag change starts a new text
              if ({1'b0, in_block_b[4]} != ab_flag_r) begin
                ab_flag_nxt = {1'b0, in_block_b[4]};
                txt_ctl.clr = 1'b1;
              end
              cnt_nxt   = '0;
              len_nxt   = '0;
              state_nxt = ST_WRITE;
            end else if (in_block_b[15:12] == rdsg_pkg::GTYPE_BASIC) begin
              name_nxt[{in_block_b[1:0], 1'b0}] = in_block_d[15:8];
              name_nxt[{in_block_b[1:0], 1'b1}] = in_block_d[7:0];
              state_nxt = ST_GRP0;
            end else begin
              state_nxt = ST_STATUS;
            end
          end
        end
      end
      ST_WRITE: begin
        txt_ctl.wr_en   = 1'b1;
        txt_ctl.wr_addr = {seg_r, cnt_r[1:0]};
        unique case (cnt_r[1:0])
          2'd0:    txt_ctl.wr_data = blk_c_r[15:8];
          2'd1:    txt_ctl.wr_data = blk_c_r[7:0];
          2'd2:    txt_ctl.wr_data = blk_d_r[15:8];
          default: txt_ctl.wr_data = blk_d_r[7:0];
        endcase
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_SCAN: begin
        // read data holds char cnt_r; the read of cnt_nxt is in flight
        priority if (txt_char == rdsg_pkg::CHAR_CR) begin
          pub_len_nxt = LW'(cnt_r);
          cnt_nxt     = '0;
          state_nxt   = ST_TEXT;
        end else if (txt_char == 8'd0) begin
          state_nxt = ST_STATUS;
        end else begin
          len_nxt = scan_len;
          if (cnt_r == AW'(rdsg_pkg::TEXT_CHARS - 1)) begin
            pub_len_nxt = scan_len;
            cnt_nxt     = '0;
            state_nxt   = ST_TEXT;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      ST_TEXT: begin
        emit.req   = 1'b1;
        emit.kind  = rdsg_pkg::KIND_TEXT;
        emit.index = 6'(cnt_r);
        emit.value = (LW'(cnt_r) < pub_len_r) ? {3'd0, txt_char} : 11'd0;
        emit.last  = (cnt_r == AW'(rdsg_pkg::TEXT_CHARS - 1));
        if (slot_free) begin
          if (emit.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      ST_GRP0: begin
        grp0_load      = 1'b1;
        freq_total_nxt = total_a;
        freq_next_nxt  = next_c;
        cnt_nxt        = '0;
        priority if (e0) begin
          state_nxt = ST_AF0;
        end else if (e1) begin
          state_nxt = ST_AF1;
        end else if (name_full) begin
          state_nxt = ST_NAME;
        end else begin
          state_nxt = ST_STATUS;
        end
      end
      ST_AF0: begin
        emit.req   = 1'b1;
        emit.kind  = rdsg_pkg::KIND_FREQ;
        emit.index = {1'b0, af_idx0_r};
        emit.value = rdsg_pkg::FREQ_BASE + {3'd0, blk_c_r[15:8]};
        emit.last  = !e1_r && !full_r;
        if (slot_free) begin
          priority if (e1_r) begin
            state_nxt = ST_AF1;
          end else if (full_r) begin
            state_nxt = ST_NAME;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_AF1: begin
        emit.req   = 1'b1;
        emit.kind  = rdsg_pkg::KIND_FREQ;
        emit.index = {1'b0, af_idx1_r};
        emit.value = rdsg_pkg::FREQ_BASE + {3'd0, blk_c_r[7:0]};
        emit.last  = !full_r;
        if (slot_free) begin
          state_nxt = full_r ? ST_NAME : ST_IDLE;
        end
      end
      ST_NAME: begin
        emit.req   = 1'b1;
        emit.kind  = rdsg_pkg::KIND_NAME;
        emit.index = 6'(cnt_r[NW-1:0]);
        emit.value = {3'd0, name_r[cnt_r[NW-1:0]]};
        emit.last  = (cnt_r[NW-1:0] == NW'(rdsg_pkg::NAME_CHARS - 1));
        if (slot_free) begin
          if (emit.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      ST_STATUS: begin
        emit.req  = 1'b1;
        emit.kind = rdsg_pkg::KIND_STATUS;
        emit.last = 1'b1;
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      pub_len_r    <= '0;
      pi_r         <= 16'd0;
      ab_flag_r    <= rdsg_pkg::FLAG_INVALID;
      freq_total_r <= 5'd0;
      freq_next_r  <= 5'd0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < rdsg_pkg::NAME_CHARS; i++) begin
        name_r[i] <= 8'd0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pub_len_r    <= pub_len_nxt;
      pi_r         <= pi_nxt;
      ab_flag_r    <= ab_flag_nxt;
      freq_total_r <= freq_total_nxt;
      freq_next_r  <= freq_next_nxt;
      name_r       <= name_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    if (in_acc) begin
      blk_c_r <= in_block_c;
      blk_d_r <= in_block_d;
      seg_r   <= in_block_b[3:0];
      ver_b_r <= in_block_b[11];
    end
    if (grp0_load) begin
      e1_r      <= e1;
      full_r    <= name_full;
      af_idx0_r <= next_a;
      af_idx1_r <= next_b;
    end
    if (load) begin
      out_kind_r        <= emit.kind;
      out_index_r       <= emit.index;
      out_value_r       <= emit.value;
      out_last_r        <= emit.last;
      out_text_length_r <= pub_len_r;
      out_pi_code_r     <= pi_r;
      out_af_count_r    <= freq_total_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_index       = out_index_r;
  assign out_value       = out_value_r;
  assign out_text_length = out_text_length_r;
  assign out_pi_code     = out_pi_code_r;
  assign out_af_count    = out_af_count_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("decoder took a second item without stalling");

  a_af_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    freq_next_r <= freq_total_r)
    else $error("af index ran past the announced count");

  a_text_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pub_len_r <= LW'(rdsg_pkg::TEXT_CHARS))
    else $error("published text length out of range");

  a_text_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == rdsg_pkg::KIND_TEXT
     && {1'b0, out_index} >= out_text_length) |-> (out_value == 11'd0))
    else $error("text char past the published length is not zero");
`endif

endmodule

FILE: hdl/rdsg_text_store.sv
// radio text store: 64 byte memory with per-entry valid bits and registered read
module rdsg_text_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rdsg_pkg::txt_ctl_t          ctl,
  input  logic [rdsg_pkg::TEXT_AW-1:0] rd_addr,
  output logic [7:0]                  rd_char
);

  logic [7:0]                    mem [rdsg_pkg::TEXT_CHARS];
  logic [rdsg_pkg::TEXT_CHARS-1:0] vld_r;
  logic [7:0]                    rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // entries never written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (ctl.clr) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_char = rd_vld_r ? rd_data_r : 8'd0;

endmodule
